FILE: hw/rtl/mhic_pkg.sv
// Shared types and constants for the magnetometer hard-iron calibrator.
`timescale 1ns / 1ps
`default_nettype none

package mhic_pkg;

    localparam int AXIS_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = AXIS_W + 1;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Tracker restart values
    localparam logic signed [AXIS_W-1:0] TRACK_MIN_RESET = 16'sd32767;
    localparam logic signed [AXIS_W-1:0] TRACK_MAX_RESET = -16'sd32767;

    // Register reset values
    localparam logic [CFG_W-1:0] CAL_COUNT_RESET = 16'd64;
    localparam logic [CFG_W-1:0] SCALE_RESET     = 16'd4096;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_COUNT = 2'd0,
        REG_SCALE_X   = 2'd1,
        REG_SCALE_Y   = 2'd2,
        REG_SCALE_Z   = 2'd3
    } cfg_reg_t;

    // Sample kinds
    typedef enum logic {
        OP_CALIBRATE = 1'b0,
        OP_MEASURE   = 1'b1
    } op_t;

    // Control from the top level to each axis unit
    typedef struct packed {
        logic fire;     // transaction moves from input to result register
        logic cal;      // calibration sample
        logic commit;   // this sample closes the run
    } axis_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mhic_axis_unit.sv
// One axis: min/max tracking, offset store and scaled offset correction.
`timescale 1ns / 1ps
`default_nettype none

module mhic_axis_unit
    import mhic_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire axis_ctrl_t               ctrl,
    input  wire logic [BYTE_W-1:0]        low_byte,
    input  wire logic [BYTE_W-1:0]        high_byte,
    input  wire logic [CFG_W-1:0]         scale,
    output logic signed [AXIS_W-1:0]      result,
    output logic                          clipped
);

    localparam int DIFF_W = OFFSET_W + 1;
    localparam int PROD_W = CFG_W + 1 + DIFF_W;
    localparam int SHIFT  = 13;
    localparam int QUOT_W = PROD_W - SHIFT;

    logic signed [AXIS_W-1:0]   min_reg, min_next;
    logic signed [AXIS_W-1:0]   max_reg, max_next;
    logic signed [OFFSET_W-1:0] offset_reg, offset_next;

    logic signed [AXIS_W-1:0]   axis;
    logic signed [AXIS_W-1:0]   min_v, max_v;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_biased;
    logic signed [QUOT_W-1:0]   quot;
    logic signed [AXIS_W-1:0]   corrected;
    logic                       clip;

    // Raw axis and updated trackers
    always_comb
    begin
        axis  = $signed({high_byte, low_byte});
        min_v = (axis < min_reg) ? axis : min_reg;
        max_v = (axis > max_reg) ? axis : max_reg;
    end

    // Tracker and offset next state
    always_comb
    begin
        min_next    = min_reg;
        max_next    = max_reg;
        offset_next = offset_reg;
        if (ctrl.fire && ctrl.cal)
        begin
            if (ctrl.commit)
            begin
                offset_next = OFFSET_W'(min_v) + OFFSET_W'(max_v);
                min_next    = TRACK_MIN_RESET;
                max_next    = TRACK_MAX_RESET;
            end
            else
            begin
                min_next = min_v;
                max_next = max_v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= TRACK_MIN_RESET;
            max_reg    <= TRACK_MAX_RESET;
            offset_reg <= '0;
        end
        else
        begin
            min_reg    <= min_next;
            max_reg    <= max_next;
            offset_reg <= offset_next;
        end
    end

    // Correction in half units: scale * (2*axis - offset_half) / 8192, toward zero
    always_comb
    begin
        diff        = DIFF_W'($signed({axis, 1'b0})) - DIFF_W'(offset_reg);
        prod        = $signed({1'b0, scale}) * diff;
        prod_biased = prod + (prod[PROD_W-1] ? PROD_W'((1 << SHIFT) - 1) : '0);
        quot        = QUOT_W'(prod_biased >>> SHIFT);
        clip        = 1'b0;
        if (quot > QUOT_W'(32767))
        begin
            corrected = 16'sh7FFF;
            clip      = 1'b1;
        end
        else if (quot < -QUOT_W'(32768))
        begin
            corrected = 16'sh8000;
            clip      = 1'b1;
        end
        else
        begin
            corrected = quot[AXIS_W-1:0];
        end
    end

    // Calibration samples pass the raw axis through
    always_comb
    begin
        result  = ctrl.cal ? axis : corrected;
        clipped = !ctrl.cal && clip;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/magnetometer_hard_iron_calibrator_top.sv
// Top level of the magnetometer hard-iron calibrator.
// Takes one sample transaction per clock cycle while in_ready is high. A sample
// is held in an input register, processed by one compare/add and one 17x18
// multiply per axis, and written to the result register, so out_valid rises
// after the sample has passed the input register and then the result register.
// in_ready drops only while the input register is full and its result cannot
// move into a stalled result register; the throughput is one sample per cycle
// while the output is not stalled.
// Calibration samples (op 0) update per-axis min/max; the sample that reaches
// calibration_count (0 counts as 1) commits offset = (max+min)/2 and restarts
// the run. Measurement samples (op 1) return scale*(axis-offset) in Q4.12,
// truncated toward zero and clipped to 16 bits. Registers are written through
// cfg_we/cfg_index/cfg_data and must only be changed while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_hard_iron_calibrator_top
    import mhic_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // Configuration write port
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    // Sample input
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    op,
    input  wire logic [BYTE_W-1:0]       x_low_byte,
    input  wire logic [BYTE_W-1:0]       x_high_byte,
    input  wire logic [BYTE_W-1:0]       y_low_byte,
    input  wire logic [BYTE_W-1:0]       y_high_byte,
    input  wire logic [BYTE_W-1:0]       z_low_byte,
    input  wire logic [BYTE_W-1:0]       z_high_byte,
    // Result output
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [AXIS_W-1:0]     x_out,
    output logic signed [AXIS_W-1:0]     y_out,
    output logic signed [AXIS_W-1:0]     z_out,
    output logic                         offsets_committed,
    output logic                         saturated
);

    // Configuration registers
    logic [CFG_W-1:0] cal_count_reg;
    logic [CFG_W-1:0] scale_x_reg, scale_y_reg, scale_z_reg;

    // Input stage
    logic              s1_valid_reg, s1_valid_next;
    op_t               op_reg;
    logic [BYTE_W-1:0] xl_reg, xh_reg, yl_reg, yh_reg, zl_reg, zh_reg;

    // Run counter
    logic [CFG_W-1:0]  samples_seen_reg, samples_seen_next;

    // Result stage
    logic              out_valid_reg, out_valid_next;
    logic signed [AXIS_W-1:0] x_out_reg, y_out_reg, z_out_reg;
    logic              committed_reg, saturated_reg;

    logic              accept;
    logic              advance;
    logic [CFG_W-1:0]  target;
    logic              commit;
    axis_ctrl_t        ctrl;
    logic signed [AXIS_W-1:0] x_res, y_res, z_res;
    logic              x_clip, y_clip, z_clip;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_count_reg <= CAL_COUNT_RESET;
            scale_x_reg   <= SCALE_RESET;
            scale_y_reg   <= SCALE_RESET;
            scale_z_reg   <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CAL_COUNT: cal_count_reg <= cfg_data;
                REG_SCALE_X:   scale_x_reg   <= cfg_data;
                REG_SCALE_Y:   scale_y_reg   <= cfg_data;
                REG_SCALE_Z:   scale_z_reg   <= cfg_data;
                default:       cal_count_reg <= cal_count_reg;
            endcase
        end
    end

    // Handshake: input stage drains whenever the result register is free
    always_comb
    begin
        advance        = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready       = !s1_valid_reg || advance;
        accept         = in_valid && in_ready;
        s1_valid_next  = accept || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !out_ready);
    end

    // Run completion check
    always_comb
    begin
        target = (cal_count_reg == '0) ? CFG_W'(1) : cal_count_reg;
        commit = ({1'b0, samples_seen_reg} + 17'd1) >= {1'b0, target};
        ctrl.fire   = advance;
        ctrl.cal    = (op_reg == OP_CALIBRATE);
        ctrl.commit = commit;
        samples_seen_next = samples_seen_reg;
        if (advance && ctrl.cal)
        begin
            samples_seen_next = commit ? '0 : samples_seen_reg + CFG_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            samples_seen_reg <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
            samples_seen_reg <= samples_seen_next;
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_t'(op);
            xl_reg <= x_low_byte;
            xh_reg <= x_high_byte;
            yl_reg <= y_low_byte;
            yh_reg <= y_high_byte;
            zl_reg <= z_low_byte;
            zh_reg <= z_high_byte;
        end
    end

    // Per-axis datapaths
    mhic_axis_unit u_axis_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .low_byte  (xl_reg),
        .high_byte (xh_reg),
        .scale     (scale_x_reg),
        .result    (x_res),
        .clipped   (x_clip)
    );

    mhic_axis_unit u_axis_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .low_byte  (yl_reg),
        .high_byte (yh_reg),
        .scale     (scale_y_reg),
        .result    (y_res),
        .clipped   (y_clip)
    );

    mhic_axis_unit u_axis_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .low_byte  (zl_reg),
        .high_byte (zh_reg),
        .scale     (scale_z_reg),
        .result    (z_res),
        .clipped   (z_clip)
    );

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_out_reg     <= x_res;
            y_out_reg     <= y_res;
            z_out_reg     <= z_res;
            committed_reg <= ctrl.cal && commit;
            saturated_reg <= x_clip || y_clip || z_clip;
        end
    end

    assign out_valid         = out_valid_reg;
    assign x_out             = x_out_reg;
    assign y_out             = y_out_reg;
    assign z_out             = z_out_reg;
    assign offsets_committed = committed_reg;
    assign saturated         = saturated_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mhic_checker.sv
// Port-level checker for the magnetometer hard-iron calibrator, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module mhic_checker
    import mhic_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_ready,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic signed [AXIS_W-1:0] x_out,
    input  wire logic signed [AXIS_W-1:0] y_out,
    input  wire logic signed [AXIS_W-1:0] z_out,
    input  wire logic                 offsets_committed,
    input  wire logic                 saturated
);

    // Input only back-pressures when a result is stuck at the output
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without a stalled result");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(x_out) && $stable(y_out)
            && $stable(z_out) && $stable(offsets_committed) && $stable(saturated)))
        else $error("stalled result changed");

    // Commit and clipping belong to different sample kinds
    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(offsets_committed && saturated))
        else $error("commit and saturation flagged together");

    // Saturation shows a clipped axis
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (x_out == 16'sh7FFF || x_out == 16'sh8000
            || y_out == 16'sh7FFF || y_out == 16'sh8000
            || z_out == 16'sh7FFF || z_out == 16'sh8000))
        else $error("saturated without a full-scale axis");

endmodule

bind magnetometer_hard_iron_calibrator_top mhic_checker u_mhic_checker (.*);

`default_nettype wire
